/* rtl/stt_pkg.sv */
package stt_pkg;

	localparam int MAX_SOURCE_BYTES = 65536;
	localparam int MAX_LEXEME_BYTES = 4095;
	localparam int KEYWORD_BYTES    = 6;
	localparam int POS_W            = $clog2(MAX_SOURCE_BYTES) + 1;
	localparam int KW_COUNT         = 16;

	localparam logic [5:0] K_STRING = 6'd34;
	localparam logic [5:0] K_NUMBER = 6'd35;
	localparam logic [5:0] K_IDENT  = 6'd36;
	localparam logic [5:0] K_END    = 6'd37;

	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_UNTERM   = 3'd1;
	localparam logic [2:0] E_OVERFLOW = 3'd2;
	localparam logic [2:0] E_TOO_LONG = 3'd3;
	localparam logic [2:0] E_ZERO     = 3'd4;
	localparam logic [2:0] E_SRC_LONG = 3'd5;

	typedef enum logic [5:0] {
		M_BETWEEN = 6'b000001,
		M_WORD    = 6'b000010,
		M_STRING  = 6'b000100,
		M_COMMENT = 6'b001000,
		M_PENDING = 6'b010000,
		M_DISCARD = 6'b100000
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       is_last;
	} src_item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] line_no;
		logic [15:0] start_offset;
		logic [11:0] lexeme_length;
		logic [30:0] number_value;
		logic [2:0]  error_code;
		logic        last_of_run;
	} tok_item_t;

	typedef logic [7:0] kw_text_t [KEYWORD_BYTES];

	localparam kw_text_t KW_TEXT [KW_COUNT] = '{
		'{"v","a","r",8'd0,8'd0,8'd0}, '{"a","n","d",8'd0,8'd0,8'd0},
		'{"c","l","a","s","s",8'd0},   '{"i","f",8'd0,8'd0,8'd0,8'd0},
		'{"n","i","l",8'd0,8'd0,8'd0}, '{"o","r",8'd0,8'd0,8'd0,8'd0},
		'{"p","r","i","n","t",8'd0},   '{"r","e","t","u","r","n"},
		'{"s","u","p","e","r",8'd0},   '{"t","h","i","s",8'd0,8'd0},
		'{"t","r","u","e",8'd0,8'd0},  '{"w","h","i","l","e",8'd0},
		'{"e","l","s","e",8'd0,8'd0},  '{"f","a","l","s","e",8'd0},
		'{"f","u","n",8'd0,8'd0,8'd0}, '{"f","o","r",8'd0,8'd0,8'd0}
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd3, 3'd3, 3'd5, 3'd2, 3'd3, 3'd2, 3'd5, 3'd6,
		3'd5, 3'd4, 3'd4, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3
	};
	localparam logic [5:0] KW_KIND [KW_COUNT] = '{
		6'd4, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
		6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33
	};

	// identifier unless the word matches a keyword in full
	function automatic logic [5:0] kw_lookup(input logic [KEYWORD_BYTES-1:0][7:0] pfx,
			input logic [11:0] len);
		logic [5:0] kind;
		logic       hit;
		kind = K_IDENT;
		for (int e = KW_COUNT - 1; e >= 0; e--) begin
			hit = (len == 12'(KW_LEN[e]));
			for (int i = 0; i < KEYWORD_BYTES; i++) begin
				if (i < int'(KW_LEN[e]) && pfx[i] != KW_TEXT[e][i]) hit = 1'b0;
			end
			if (hit) kind = KW_KIND[e];
		end
		return kind;
	endfunction

	// single-character operator kind; valid low for other bytes
	function automatic logic [6:0] single_kind(input logic [7:0] c);
		logic [6:0] r;
		case (c)
			"(": r = {1'b1, 6'd0};
			")": r = {1'b1, 6'd1};
			"=": r = {1'b1, 6'd2};
			";": r = {1'b1, 6'd5};
			"+": r = {1'b1, 6'd6};
			"/": r = {1'b1, 6'd7};
			"-": r = {1'b1, 6'd8};
			"{": r = {1'b1, 6'd9};
			"}": r = {1'b1, 6'd10};
			".": r = {1'b1, 6'd11};
			"*": r = {1'b1, 6'd12};
			"!": r = {1'b1, 6'd13};
			">": r = {1'b1, 6'd15};
			"<": r = {1'b1, 6'd17};
			default: r = 7'd0;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] double_kind(input logic [7:0] c);
		logic [6:0] r;
		case (c)
			"=": r = {1'b1, 6'd3};
			"!": r = {1'b1, 6'd14};
			">": r = {1'b1, 6'd16};
			"<": r = {1'b1, 6'd18};
			default: r = 7'd0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] sat16(input logic [POS_W-1:0] x);
		return (x > POS_W'(65535)) ? 16'hFFFF : x[15:0];
	endfunction

endpackage

/* rtl/source_text_tokenizer.sv */
// source_text_tokenizer
// Source bytes enter on the src channel (src_valid / src_stall, payload
// src_item with char_byte and is_last). Tokens leave on the tok channel
// (tok_valid / tok_stall, payload tok_item). An item moves at a clock edge
// where valid is high and stall is low.
// Each byte is scanned in the cycle it is accepted: the scanner state and up
// to three results are computed by one pass of logic and the results are
// written into a four-entry output queue. A token enters the queue at the
// clock edge that accepts the byte that closes it. One byte is taken per
// cycle while the queue holds at most one item; a byte that yields several
// tokens holds the input until the queue has drained back to one item.
// The byte flagged is_last closes any open token, adds the end token (or the
// error result stands in for it) and returns the scanner to its start state.
// After an error, bytes are swallowed without results until the last byte.
// When the receiver stalls, the queue fills and src_stall rises; nothing is
// lost. arst_n clears the scanner and empties the queue at once.
module source_text_tokenizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  stt_pkg::src_item_t src_item,
	output logic               tok_valid,
	input  logic               tok_stall,
	output stt_pkg::tok_item_t tok_item
);
	import stt_pkg::*;

	scan_mode_t                   mode_q;
	logic [7:0]                   pend_q;
	logic [KEYWORD_BYTES-1:0][7:0] pfx_q;
	logic [11:0]                  len_q;
	logic                         dig_q;
	logic [30:0]                  val_q;
	logic                         ovf_q;
	logic [15:0]                  line_q;
	logic [POS_W-1:0]             pos_q;
	logic [15:0]                  ts_q;

	// output queue
	tok_item_t  fifo_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	scan_mode_t                   mode_n;
	logic [7:0]                   pend_n;
	logic [KEYWORD_BYTES-1:0][7:0] pfx_n;
	logic [11:0]                  len_n;
	logic                         dig_n;
	logic [30:0]                  val_n;
	logic                         ovf_n;
	logic [15:0]                  line_n;
	logic [POS_W-1:0]             pos_n;
	logic [15:0]                  ts_n;
	tok_item_t                    res [3];
	logic [1:0]                   nres;

	logic src_take, tok_take;
	assign src_take  = src_valid && !src_stall;
	assign tok_take  = tok_valid && !tok_stall;
	assign src_stall = (cnt_q > 3'd1);
	assign tok_valid = (cnt_q != 3'd0);
	assign tok_item  = fifo_q[rp_q];

	function automatic tok_item_t mk(input logic [5:0] kind, input logic [15:0] ln,
			input logic [15:0] off, input logic [11:0] len, input logic [30:0] val,
			input logic [2:0] err, input logic last);
		tok_item_t t;
		t.token_kind    = kind;
		t.line_no       = ln;
		t.start_offset  = off;
		t.lexeme_length = len;
		t.number_value  = val;
		t.error_code    = err;
		t.last_of_run   = last;
		return t;
	endfunction

	always_comb begin
		logic [7:0]  c;
		logic [15:0] p;
		logic        go_between, go_word;
		logic [34:0] prod;
		logic [6:0]  sk, dk, pk, pn;
		c          = src_item.char_byte;
		p          = pos_q[15:0];
		go_between = 1'b0;
		go_word    = 1'b0;
		prod       = '0;
		mode_n = mode_q; pend_n = pend_q; pfx_n = pfx_q; len_n = len_q;
		dig_n = dig_q; val_n = val_q; ovf_n = ovf_q; line_n = line_q;
		pos_n = pos_q; ts_n = ts_q;
		nres = 2'd0;
		for (int i = 0; i < 3; i++) res[i] = '0;
		sk = single_kind(c);
		dk = double_kind(pend_q);
		pk = single_kind(pend_q);

		if (mode_q != M_DISCARD) begin
			if (pos_q >= POS_W'(MAX_SOURCE_BYTES)) begin
				res[nres] = mk(K_END, line_n, sat16(pos_q), 12'd0, 31'd0, E_SRC_LONG, 1'b1);
				nres = nres + 2'd1;
				mode_n = M_DISCARD;
			end else begin
				pos_n = pos_q + POS_W'(1);
				case (mode_q)
					M_WORD: begin
						if (c == " " || c == 8'h0A || c == 8'd0 || sk[6]) begin
							// close the word, then rescan this byte unless the number overflowed
							mode_n = M_BETWEEN;
							if (dig_q && ovf_q) begin
								res[nres] = mk(K_END, line_n, ts_q, len_q, 31'd0,
									E_OVERFLOW, 1'b1);
								nres = nres + 2'd1;
								mode_n = M_DISCARD;
							end else begin
								res[nres] = mk(dig_q ? K_NUMBER : kw_lookup(pfx_q, len_q),
									line_n, ts_q, len_q, dig_q ? val_q : 31'd0, E_NONE, 1'b0);
								nres = nres + 2'd1;
								go_between = 1'b1;
							end
						end else begin
							go_word = 1'b1;
						end
					end
					M_STRING: begin
						if (c == 8'h0A || c == 8'd0) begin
							res[nres] = mk(K_END, line_n, ts_q, len_q, 31'd0, E_UNTERM, 1'b1);
							nres = nres + 2'd1;
							mode_n = M_DISCARD;
						end else if (len_q >= 12'(MAX_LEXEME_BYTES)) begin
							res[nres] = mk(K_END, line_n, ts_q, len_q, 31'd0,
								E_TOO_LONG, 1'b1);
							nres = nres + 2'd1;
							mode_n = M_DISCARD;
						end else begin
							len_n = len_q + 12'd1;
							if (c == "\"") begin
								res[nres] = mk(K_STRING, line_n, ts_q, len_n, 31'd0,
									E_NONE, 1'b0);
								nres = nres + 2'd1;
								mode_n = M_BETWEEN;
							end
						end
					end
					M_COMMENT: begin
						if (c == 8'h0A) begin
							if (line_n != 16'hFFFF) line_n = line_n + 16'd1;
							mode_n = M_BETWEEN;
						end
					end
					M_PENDING: begin
						if (c == "=" && dk[6]) begin
							res[nres] = mk(dk[5:0], line_n, ts_q, 12'd2, 31'd0, E_NONE, 1'b0);
							nres = nres + 2'd1;
							mode_n = M_BETWEEN;
						end else if (c == "/" && pend_q == "/") begin
							mode_n = M_COMMENT;
						end else begin
							res[nres] = mk(pk[5:0], line_n, ts_q,
								12'd1, 31'd0, E_NONE, 1'b0);
							nres = nres + 2'd1;
							mode_n = M_BETWEEN;
							go_between = 1'b1;
						end
					end
					default: go_between = 1'b1;
				endcase
			end
		end

		// token start
		if (go_between) begin
			mode_n = M_BETWEEN;
			if (c == " ") begin
			end else if (c == 8'h0A) begin
				if (line_n != 16'hFFFF) line_n = line_n + 16'd1;
			end else if (c == 8'd0) begin
				res[nres] = mk(K_END, line_n, p, 12'd0, 31'd0, E_ZERO, 1'b1);
				nres = nres + 2'd1;
				mode_n = M_DISCARD;
			end else if (c == "\"") begin
				mode_n = M_STRING;
				ts_n   = p;
				len_n  = 12'd1;
			end else if (sk[6]) begin
				if (double_kind(c) != 7'd0 || c == "/") begin
					mode_n = M_PENDING;
					pend_n = c;
					ts_n   = p;
				end else begin
					res[nres] = mk(sk[5:0], line_n, p, 12'd1, 31'd0, E_NONE, 1'b0);
					nres = nres + 2'd1;
				end
			end else begin
				mode_n  = M_WORD;
				ts_n    = p;
				len_n   = 12'd0;
				dig_n   = 1'b1;
				val_n   = 31'd0;
				ovf_n   = 1'b0;
				go_word = 1'b1;
			end
		end

		// append a byte to the current word
		if (go_word) begin
			if (len_n >= 12'(MAX_LEXEME_BYTES)) begin
				res[nres] = mk(K_END, line_n, ts_n, len_n, 31'd0, E_TOO_LONG, 1'b1);
				nres = nres + 2'd1;
				mode_n = M_DISCARD;
			end else begin
				if (len_n < 12'(KEYWORD_BYTES)) pfx_n[len_n[2:0]] = c;
				len_n = len_n + 12'd1;
				if (dig_n) begin
					if (c >= 8'd48 && c <= 8'd57) begin
						if (!ovf_n) begin
							prod = {4'd0, val_n} * 35'd10 + {27'd0, c - 8'd48};
							if (prod > 35'h7FFFFFFF) ovf_n = 1'b1;
							else val_n = prod[30:0];
						end
					end else begin
						dig_n = 1'b0;
					end
				end
			end
		end

		// end of source text
		pn = single_kind(pend_n);
		if (src_item.is_last) begin
			if (mode_n == M_WORD) begin
				mode_n = M_BETWEEN;
				if (dig_n && ovf_n) begin
					res[nres] = mk(K_END, line_n, ts_n, len_n, 31'd0, E_OVERFLOW, 1'b1);
					nres = nres + 2'd1;
					mode_n = M_DISCARD;
				end else begin
					res[nres] = mk(dig_n ? K_NUMBER : kw_lookup(pfx_n, len_n), line_n,
						ts_n, len_n, dig_n ? val_n : 31'd0, E_NONE, 1'b0);
					nres = nres + 2'd1;
				end
			end else if (mode_n == M_PENDING) begin
				res[nres] = mk(pn[5:0], line_n, ts_n, 12'd1, 31'd0,
					E_NONE, 1'b0);
				nres = nres + 2'd1;
				mode_n = M_BETWEEN;
			end else if (mode_n == M_STRING) begin
				res[nres] = mk(K_END, line_n, ts_n, len_n, 31'd0, E_UNTERM, 1'b1);
				nres = nres + 2'd1;
				mode_n = M_DISCARD;
			end
			if (mode_n != M_DISCARD && nres != 2'd3) begin
				res[nres] = mk(K_END, line_n, sat16(pos_n), 12'd0, 31'd0, E_NONE, 1'b1);
				nres = nres + 2'd1;
			end
			// restart for the next source text
			mode_n = M_BETWEEN; pend_n = 8'd0; len_n = 12'd0; dig_n = 1'b1;
			val_n = 31'd0; ovf_n = 1'b0; line_n = 16'd1; pos_n = '0; ts_n = 16'd0;
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_BETWEEN;
			pend_q <= 8'd0;
			len_q  <= 12'd0;
			dig_q  <= 1'b1;
			val_q  <= 31'd0;
			ovf_q  <= 1'b0;
			line_q <= 16'd1;
			pos_q  <= '0;
			ts_q   <= 16'd0;
		end else if (src_take) begin
			mode_q <= mode_n;
			pend_q <= pend_n;
			len_q  <= len_n;
			dig_q  <= dig_n;
			val_q  <= val_n;
			ovf_q  <= ovf_n;
			line_q <= line_n;
			pos_q  <= pos_n;
			ts_q   <= ts_n;
		end
	end

	// word prefix holds only bytes already written
	always_ff @(posedge clk) begin
		if (src_take) pfx_q <= pfx_n;
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (src_take) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < nres) fifo_q[wp_q + 2'(i)] <= res[i];
			end
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (src_take) wp_q <= wp_q + nres;
			if (tok_take) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + (src_take ? {1'b0, nres} : 3'd0) - {2'd0, tok_take};
		end
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4) else $error("output queue overrun");
	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		src_take && src_item.is_last |=> mode_q == M_BETWEEN && line_q == 16'd1 &&
		pos_q == '0) else $error("scanner did not restart after last byte");
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		src_take && src_item.is_last && mode_q != M_DISCARD |-> nres != 2'd0)
		else $error("last byte gave no closing result");
	a_discard_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		src_take && mode_q == M_DISCARD && !src_item.is_last |-> nres == 2'd0)
		else $error("result emitted while discarding");

endmodule
